>>> rtl/core/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

  localparam int DEPTH       = 1024;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int MODE_W      = 3;
  localparam int COUNT_OUT_W = 11;
  localparam int CQ_DEPTH    = 2;
  localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    K_NOP,
    K_PUSH,
    K_POP,
    K_PEEK
  } op_kind_t;

  typedef enum logic {
    BK_RUN,
    BK_RDWAIT
  } bk_state_t;

  typedef struct packed {
    op_kind_t                 kind;
    logic                     at_back;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  read_value;
    logic                     value_valid;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     is_empty;
    logic                     push_dropped;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/rbd_if.sv
// Valid/ready channel interfaces for deque operations and results.
`timescale 1ns / 1ps
`default_nettype none

interface rbd_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface rbd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               value_valid;
  logic [10:0]        entry_count;
  logic               is_empty;
  logic               push_dropped;

  modport source (output valid, output read_value, output value_valid,
                  output entry_count, output is_empty, output push_dropped,
                  input ready);
  modport sink   (input valid, input read_value, input value_valid,
                  input entry_count, input is_empty, input push_dropped,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/ring_buffer_deque.sv
// Top level of the ring buffer deque: front decoder/queue plus back-end store.
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of up to DEPTH (1024) signed 32-bit entries in a ring
// store. Each transfer on in_ch names one operation (push/pop/peek at front or
// back) and yields exactly one transfer on out_ch, in order. A two-entry
// command queue decouples the decoder from the store, so in_ch keeps taking
// transfers while a result waits on out_ch. Push, dropped push, empty pop or
// peek, and unused modes finish in the run state; a pop or peek that finds
// an entry also passes the read-wait state for the registered read port,
// taking no new command meanwhile. Pushes sustain one per cycle while out_ch
// takes results. Results give the count after the operation, an empty flag,
// a valid flag for the read value (zero when not valid) and a flag for a push
// dropped when full. No clearing pass after reset: stale entries are never read.
module ring_buffer_deque
  import rbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rbd_in_if.sink    in_ch,
  rbd_out_if.source out_ch
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  res_t out_res;

  // decode and buffer incoming operations
  rbd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_mode       (in_ch.mode),
    .in_push_value (in_ch.push_value),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  // execute against the ring store and hold the result
  rbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.read_value   = out_res.read_value;
  assign out_ch.value_valid  = out_res.value_valid;
  assign out_ch.entry_count  = out_res.entry_count;
  assign out_ch.is_empty     = out_res.is_empty;
  assign out_ch.push_dropped = out_res.push_dropped;

endmodule

`default_nettype wire

>>> rtl/core/rbd_front.sv
// Front end: decodes operation modes and buffers commands in a small queue.
`timescale 1ns / 1ps
`default_nettype none

module rbd_front
  import rbd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [VAL_W-1:0]  in_push_value,
  output logic                     cmd_valid,
  output cmd_t                     cmd,
  input  logic                     cmd_take
);

  cmd_t                ent_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t                dec_cmd;
  logic                push, pop;

  always_comb begin
    dec_cmd.value   = in_push_value;
    dec_cmd.at_back = 1'b0;
    dec_cmd.kind    = K_NOP;
    case (in_mode)
      MODE_PUSH_FRONT: begin dec_cmd.kind = K_PUSH; end
      MODE_PUSH_BACK:  begin dec_cmd.kind = K_PUSH; dec_cmd.at_back = 1'b1; end
      MODE_POP_FRONT:  begin dec_cmd.kind = K_POP;  end
      MODE_POP_BACK:   begin dec_cmd.kind = K_POP;  dec_cmd.at_back = 1'b1; end
      MODE_PEEK_FRONT: begin dec_cmd.kind = K_PEEK; end
      MODE_PEEK_BACK:  begin dec_cmd.kind = K_PEEK; dec_cmd.at_back = 1'b1; end
      default:         begin dec_cmd.kind = K_NOP;  end
    endcase
  end

  assign in_ready  = (cnt_r != CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = ent_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_take;

  always_comb begin
    wr_ptr_nxt = push ? CQ_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? CQ_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rbd_back.sv
// Back end: ring store, head/tail/count bookkeeping and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rbd_back
  import rbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cmd_valid,
  input  cmd_t  cmd,
  output logic  cmd_take,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(p - 1'b1);
  endfunction

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  bk_state_t        state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  res_t             res_r, res_nxt;
  logic             out_load;
  logic             out_free;
  logic             is_full, is_emp;
  logic             wr_en, rd_en;
  logic [PTR_W-1:0] wr_addr, rd_addr;

  assign out_free = !out_valid_r || out_ready;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_emp   = (count_r == '0);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    cmd_take  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    out_load  = 1'b0;
    res_nxt   = '0;
    case (state_r)
      BK_RUN: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          case (cmd.kind)
            K_PUSH: begin
              out_load = 1'b1;
              if (is_full) begin
                res_nxt.push_dropped = 1'b1;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                if (cmd.at_back) begin
                  wr_addr  = tail_r;
                  tail_nxt = ptr_inc(tail_r);
                end else begin
                  wr_addr  = ptr_dec(head_r);
                  head_nxt = ptr_dec(head_r);
                end
              end
              res_nxt.entry_count = COUNT_OUT_W'(count_nxt);
              res_nxt.is_empty    = (count_nxt == '0);
            end
            K_POP, K_PEEK: begin
              if (is_emp) begin
                out_load         = 1'b1;
                res_nxt.is_empty = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = BK_RDWAIT;
                rd_addr   = cmd.at_back ? ptr_dec(tail_r) : head_r;
                if (cmd.kind == K_POP) begin
                  count_nxt = count_r - 1'b1;
                  if (cmd.at_back) begin
                    tail_nxt = ptr_dec(tail_r);
                  end else begin
                    head_nxt = ptr_inc(head_r);
                  end
                end
              end
            end
            default: begin
              out_load            = 1'b1;
              res_nxt.entry_count = COUNT_OUT_W'(count_r);
              res_nxt.is_empty    = is_emp;
            end
          endcase
        end
      end
      BK_RDWAIT: begin
        // count_r already holds the post-pop value here
        out_load            = 1'b1;
        res_nxt.read_value  = rdata_r;
        res_nxt.value_valid = 1'b1;
        res_nxt.entry_count = COUNT_OUT_W'(count_r);
        res_nxt.is_empty    = is_emp;
        state_nxt           = BK_RUN;
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_rdwait_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_RDWAIT |-> !out_valid_r)
    else $error("result register busy while memory read is in flight");

  a_rdwait_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_RDWAIT |=> out_valid_r && state_r == BK_RUN)
    else $error("memory read did not produce a result");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the ring buffer deque: random push/pop/peek traffic.
`timescale 1ns / 1ps

module tb_top;
  import rbd_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  // No transfer on either channel for this many cycles means the block hung.
  // Correct runs idle only through sender gaps, receiver stalls and drain pauses.
  localparam int IDLE_LIMIT   = 4000;
  // Quiet cycles after the last result, to catch any stray extra transfer.
  localparam int TAIL_CYCLES  = 30;

  // Mode codes that the block must treat as no-ops.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
    int                      gap;            // idle cycles before valid rises
    bit                      hold_for_drain; // wait until all results are back
  } deque_op_t;

  logic clk;
  logic rst_n;

  rbd_in_if  in_ch ();
  rbd_out_if out_ch ();

  ring_buffer_deque DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // ---------------------------------------------------------------------------
  // Shadow deque. Updated once per accepted input transfer, in transfer order,
  // and yields the result the block must return for that operation.
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] shadow_store [DEPTH];
  logic [PTR_W-1:0]        shadow_head = '0;  // oldest front entry
  logic [PTR_W-1:0]        shadow_tail = '0;  // slot after the back entry
  int                      shadow_count = 0;

  // Run statistics for the closing summary.
  int n_pushes      = 0;
  int n_dropped     = 0;
  int n_reads       = 0;
  int n_empty_reads = 0;
  int n_noops       = 0;
  int peak_count    = 0;

  // Pointers are PTR_W bits wide and DEPTH is a power of two, so plain
  // increment/decrement wraps around the ring.
  function automatic res_t deque_predict(input logic [MODE_W-1:0] mode,
                                         input logic signed [VAL_W-1:0] value);
    res_t r;
    bit   full;
    bit   empty;
    r     = '0;
    full  = (shadow_count >= DEPTH);
    empty = (shadow_count == 0);
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        n_pushes++;
        if (full) begin
          r.push_dropped = 1'b1;
          n_dropped++;
        end else if (mode == MODE_PUSH_FRONT) begin
          shadow_head               = shadow_head - 1'b1;
          shadow_store[shadow_head] = value;
          shadow_count++;
        end else begin
          shadow_store[shadow_tail] = value;
          shadow_tail               = shadow_tail + 1'b1;
          shadow_count++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (empty) begin
          n_empty_reads++;
        end else begin
          n_reads++;
          r.value_valid = 1'b1;
          case (mode)
            MODE_POP_FRONT: begin
              r.read_value = shadow_store[shadow_head];
              shadow_head  = shadow_head + 1'b1;
              shadow_count--;
            end
            MODE_POP_BACK: begin
              shadow_tail  = shadow_tail - 1'b1;
              r.read_value = shadow_store[shadow_tail];
              shadow_count--;
            end
            MODE_PEEK_FRONT: r.read_value = shadow_store[shadow_head];
            default:         r.read_value = shadow_store[shadow_tail - 1'b1];
          endcase
        end
      end
      default: n_noops++;
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    r.entry_count = shadow_count[COUNT_OUT_W-1:0];
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  // Results still owed by the block, oldest first.
  res_t pending_results[$];

  int mismatches   = 0;
  int results_seen = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s got 0x%h expected 0x%h",
             $time, results_seen, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation. gen_count follows the occupancy the queued operations
  // will produce, so the random phases can steer the deque to full.
  // ---------------------------------------------------------------------------
  deque_op_t op_queue[$];
  int        gen_count = 0;
  bit        tx_calm   = 1'b0;  // stretch with no sender gaps

  task automatic queue_op(input logic [MODE_W-1:0] mode,
                          input logic signed [VAL_W-1:0] value, input bit hold);
    deque_op_t op;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    op.mode           = mode;
    op.value          = value;
    op.gap            = tx_calm ? 0 : $urandom_range(0, 9);
    op.hold_for_drain = hold;
    op_queue = {op_queue, op};
    if (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK) begin
      if (gen_count < DEPTH) gen_count++;
    end else if (mode == MODE_POP_FRONT || mode == MODE_POP_BACK) begin
      if (gen_count > 0) gen_count--;
    end
  endtask

  // Mostly full-range random, with the sign and zero corners mixed in.
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Percentages pick the operation class; whatever is left goes to spare codes.
  task automatic queue_random(input int push_pct, input int pop_pct,
                              input int peek_pct, input bit hold);
    int                r;
    bit                back;
    logic [MODE_W-1:0] m;
    r    = $urandom_range(0, 99);
    back = 1'($urandom_range(0, 1));
    if (r < push_pct)
      m = back ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    else if (r < push_pct + pop_pct)
      m = back ? MODE_POP_BACK : MODE_POP_FRONT;
    else if (r < push_pct + pop_pct + peek_pct)
      m = back ? MODE_PEEK_BACK : MODE_PEEK_FRONT;
    else
      m = back ? MODE_SPARE_HI : MODE_SPARE_LO;
    queue_op(m, rand_value(), hold);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents one operation at a time, honoring its gap and, when
  // flagged, holding off until every outstanding result has been returned.
  // valid is assigned exactly once per edge, so back-to-back transfers keep it
  // high without a glitch.
  // ---------------------------------------------------------------------------
  deque_op_t cur_op;
  bit        op_live = 1'b0;

  always @(posedge clk) begin : driver
    logic go;
    res_t pred;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.mode       <= '0;
      in_ch.push_value <= '0;
    end else begin
      go = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        pred            = deque_predict(cur_op.mode, cur_op.value);
        pending_results = {pending_results, pred};
        op_live         = 1'b0;
      end
      if (!op_live && op_queue.size() != 0) begin
        cur_op  = op_queue[0];
        op_queue.delete(0);
        op_live = 1'b1;
      end
      if (op_live) begin
        if (cur_op.gap > 0)
          cur_op.gap--;
        else if (!(cur_op.hold_for_drain && pending_results.size() != 0))
          go = 1'b1;
      end
      in_ch.valid <= go;
      if (go) begin
        in_ch.mode       <= cur_op.mode;
        in_ch.push_value <= cur_op.value;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results with random back-pressure and checks each one
  // field by field against the oldest prediction.
  // ---------------------------------------------------------------------------
  int rx_stall = 0;
  bit rx_calm  = 1'b0;  // stretch with ready held high

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected, read_value",
                          out_ch.read_value, '0);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_ch.read_value !== want.read_value)
            report_mismatch("read_value", out_ch.read_value, want.read_value);
          if (out_ch.value_valid !== want.value_valid)
            report_mismatch("value_valid", 32'(out_ch.value_valid),
                            32'(want.value_valid));
          if (out_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(out_ch.entry_count),
                            32'(want.entry_count));
          if (out_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(out_ch.is_empty), 32'(want.is_empty));
          if (out_ch.push_dropped !== want.push_dropped)
            report_mismatch("push_dropped", 32'(out_ch.push_dropped),
                            32'(want.push_dropped));
        end
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        rx_stall = rx_calm ? 0 : $urandom_range(0, 9);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      out_ch.ready <= (rx_stall == 0);
    end
  end

  // Hang detection: counts consecutive cycles without any transfer.
  int stuck_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    rst_n <= 1'b0;

    // Directed: reads and spare codes on the empty deque.
    queue_op(MODE_POP_FRONT, rand_value(), 1'b0);
    queue_op(MODE_POP_BACK, rand_value(), 1'b0);
    queue_op(MODE_PEEK_FRONT, rand_value(), 1'b0);
    queue_op(MODE_PEEK_BACK, rand_value(), 1'b0);
    queue_op(MODE_SPARE_LO, rand_value(), 1'b0);
    queue_op(MODE_SPARE_HI, rand_value(), 1'b0);
    // Extreme values at both ends; front push wraps head below slot 0.
    queue_op(MODE_PUSH_BACK, 32'sh7FFF_FFFF, 1'b0);
    queue_op(MODE_PUSH_FRONT, 32'sh8000_0000, 1'b0);
    queue_op(MODE_PEEK_FRONT, rand_value(), 1'b0);
    queue_op(MODE_PEEK_BACK, rand_value(), 1'b0);
    queue_op(MODE_PUSH_BACK, '0, 1'b0);
    queue_op(MODE_PUSH_FRONT, -32'sd1, 1'b0);
    // Spare code on a non-empty deque must leave it alone.
    queue_op(MODE_SPARE_LO, 32'sh1234_5678, 1'b0);
    queue_op(MODE_POP_BACK, rand_value(), 1'b0);
    queue_op(MODE_POP_FRONT, rand_value(), 1'b0);
    queue_op(MODE_POP_FRONT, rand_value(), 1'b0);
    queue_op(MODE_PEEK_BACK, rand_value(), 1'b0);
    queue_op(MODE_POP_BACK, rand_value(), 1'b0);
    queue_op(MODE_POP_FRONT, rand_value(), 1'b0);
    // Single entry taken from the opposite end, both wrap directions.
    queue_op(MODE_PUSH_FRONT, 32'sh5555_5555, 1'b0);
    queue_op(MODE_POP_BACK, rand_value(), 1'b0);
    queue_op(MODE_PUSH_BACK, 32'shAAAA_AAAA, 1'b0);
    queue_op(MODE_PEEK_FRONT, rand_value(), 1'b0);
    queue_op(MODE_POP_FRONT, rand_value(), 1'b0);

    // Shallow mixed traffic; the first op waits for the directed results.
    for (n = 0; n < 20; n++) queue_random(40, 35, 20, n == 0);
    // Push-heavy walk up to full occupancy.
    while (gen_count < DEPTH) queue_random(98, 1, 1, 1'b0);
    // Pushes against a full deque get dropped; peeks see both ends.
    queue_op(MODE_PUSH_BACK, rand_value(), 1'b1);
    for (n = 0; n < 8; n++) queue_random(60, 0, 40, 1'b0);
    // Leave full again with a drained pipeline, then pop-heavy traffic.
    for (n = 0; n < 4; n++) queue_random(0, 50, 50, n == 0);
    for (n = 0; n < 20; n++) queue_random(10, 70, 20, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || op_live) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d ops: %0d pushes (%0d dropped), %0d reads, %0d on empty, %0d no-ops",
             n_pushes + n_reads + n_empty_reads + n_noops, n_pushes, n_dropped,
             n_reads, n_empty_reads, n_noops);
    $display("Peak occupancy %0d of %0d; %0d results checked, %0d mismatches",
             peak_count, DEPTH, results_seen, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
